// ----- hdl/fjop_pkg.sv -----
// Shared constants, types and helper functions for the flat JSON object parser.
`timescale 1ns / 1ps
package fjop_pkg;

  // Whitespace run store
  localparam int RUN_MAX = 32;
  localparam int RUN_W   = $clog2(RUN_MAX + 1);

  // Parse phases
  localparam logic [3:0] PH_OPEN   = 4'd0;
  localparam logic [3:0] PH_FIRST  = 4'd1;
  localparam logic [3:0] PH_KEY    = 4'd2;
  localparam logic [3:0] PH_STR    = 4'd3;
  localparam logic [3:0] PH_ESC    = 4'd4;
  localparam logic [3:0] PH_HEX    = 4'd5;
  localparam logic [3:0] PH_COLON  = 4'd6;
  localparam logic [3:0] PH_VALUE  = 4'd7;
  localparam logic [3:0] PH_BARE   = 4'd8;
  localparam logic [3:0] PH_AFTER  = 4'd9;
  localparam logic [3:0] PH_DONE   = 4'd10;
  localparam logic [3:0] PH_REJECT = 4'd11;

  // Result kinds
  localparam logic [2:0] K_KEY  = 3'd0;
  localparam logic [2:0] K_VAL  = 3'd1;
  localparam logic [2:0] K_PAIR = 3'd2;
  localparam logic [2:0] K_ACC  = 3'd3;
  localparam logic [2:0] K_REJ  = 3'd4;

  // Command codes on the input channel
  localparam logic CMD_TEXT = 1'b0;
  localparam logic CMD_END  = 1'b1;

  // Characters
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BS     = 8'h08;
  localparam logic [7:0] CH_FF     = 8'h0C;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LOW_B  = 8'h62;
  localparam logic [7:0] CH_LOW_F  = 8'h66;
  localparam logic [7:0] CH_LOW_N  = 8'h6E;
  localparam logic [7:0] CH_LOW_R  = 8'h72;
  localparam logic [7:0] CH_LOW_T  = 8'h74;
  localparam logic [7:0] CH_LOW_U  = 8'h75;

  // UTF-8 lead and continuation marks
  localparam logic [7:0]  UTF_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF_CONT  = 8'h80;
  localparam logic [15:0] UTF_ONE_LIMIT = 16'h0080;
  localparam logic [15:0] UTF_TWO_LIMIT = 16'h0800;

  // Controller to datapath
  typedef struct packed {
    logic accept;  // latch the current request and its result plan
    logic pop;     // move the next planned result into the output register
  } fjop_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic gen_any;    // the presented request produces at least one result
    logic plan_any;   // results still waiting in the plan
    logic plan_last;  // exactly one result left in the plan
    logic out_free;   // output register can be loaded this cycle
  } fjop_stat_t;

  function automatic logic is_ws(input logic [7:0] c);
    return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR) || (c == CH_LF);
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end
    return r;
  endfunction

endpackage

// ----- hdl/fjop_ctrl.sv -----
// Controller: accepts one request at a time and sequences its results out.
`timescale 1ns / 1ps
module fjop_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  fjop_pkg::fjop_stat_t stat,
  output fjop_pkg::fjop_cmd_t  cmd
);
  import fjop_pkg::*;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EMIT = 1'b1;

  logic state;
  logic state_next;

  assign in_ready   = (state == ST_IDLE);
  assign cmd.accept = (state == ST_IDLE) && in_valid;
  assign cmd.pop    = (state == ST_EMIT) && stat.out_free && stat.plan_any;

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid && stat.gen_any) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (cmd.pop && stat.plan_last) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hdl/fjop_dp.sv -----
// Datapath: parse state, whitespace run store, result plan and output register.
`timescale 1ns / 1ps
module fjop_dp (
  input  logic                 clk,
  input  logic                 rst,
  input  fjop_pkg::fjop_cmd_t  cmd,
  output fjop_pkg::fjop_stat_t stat,
  input  logic                 in_cmd,
  input  logic [7:0]           in_byte,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [2:0]           out_kind,
  output logic [7:0]           out_byte,
  output logic                 out_last
);
  import fjop_pkg::*;

  // Parse state
  logic [3:0]         phase,      phase_next;
  logic               in_value,   in_value_next;
  logic [1:0]         hex_count,  hex_count_next;
  logic [15:0]        code_point, code_point_next;
  logic [RUN_W-1:0]   run_len,    run_len_next;
  logic [RUN_MAX-1:0] run_kinds,  run_kinds_next;

  // Plan decoded for the presented request
  logic       flush;
  logic [1:0] tail_cnt_new;
  logic [2:0] tail_kind_new [3];
  logic [7:0] tail_byte_new [3];

  // Plan registers
  logic [RUN_W-1:0]   run_left;
  logic [RUN_MAX-1:0] run_bits;
  logic [1:0]         tail_cnt;
  logic [2:0]         tail_kind [3];
  logic [7:0]         tail_byte [3];

  logic [2:0]  str_kind;
  logic [4:0]  hv;
  logic [15:0] cp;

  assign str_kind = in_value ? K_VAL : K_KEY;
  assign hv       = hex_val(in_byte);
  assign cp       = {code_point[11:0], hv[3:0]};

  always_comb begin
    phase_next      = phase;
    in_value_next   = in_value;
    hex_count_next  = hex_count;
    code_point_next = code_point;
    run_len_next    = run_len;
    run_kinds_next  = run_kinds;
    flush           = 1'b0;
    tail_cnt_new    = 2'd0;
    for (int i = 0; i < 3; i++) begin
      tail_kind_new[i] = K_KEY;
      tail_byte_new[i] = 8'd0;
    end

    if (in_cmd == CMD_END) begin
      tail_cnt_new     = 2'd1;
      tail_kind_new[0] = (phase == PH_DONE) ? K_ACC : K_REJ;
      phase_next       = PH_OPEN;
      in_value_next    = 1'b0;
      hex_count_next   = 2'd0;
      code_point_next  = 16'd0;
      run_len_next     = '0;
      run_kinds_next   = '0;
    end else begin
      unique case (phase)
        PH_OPEN: begin
          if (!is_ws(in_byte)) phase_next = (in_byte == CH_LBRACE) ? PH_FIRST : PH_REJECT;
        end
        PH_FIRST: begin
          if (!is_ws(in_byte)) begin
            if (in_byte == CH_RBRACE) begin
              phase_next = PH_DONE;
            end else if (in_byte == CH_QUOTE) begin
              in_value_next = 1'b0;
              phase_next    = PH_STR;
            end else begin
              phase_next = PH_REJECT;
            end
          end
        end
        PH_KEY: begin
          if (!is_ws(in_byte)) begin
            if (in_byte == CH_QUOTE) begin
              in_value_next = 1'b0;
              phase_next    = PH_STR;
            end else begin
              phase_next = PH_REJECT;
            end
          end
        end
        PH_STR: begin
          if (in_byte == CH_QUOTE) begin
            if (in_value) begin
              tail_cnt_new     = 2'd1;
              tail_kind_new[0] = K_PAIR;
              phase_next       = PH_AFTER;
            end else begin
              phase_next = PH_COLON;
            end
          end else if (in_byte == CH_BSLASH) begin
            phase_next = PH_ESC;
          end else begin
            tail_cnt_new     = 2'd1;
            tail_kind_new[0] = str_kind;
            tail_byte_new[0] = in_byte;
          end
        end
        PH_ESC: begin
          tail_kind_new[0] = str_kind;
          phase_next       = PH_STR;
          tail_cnt_new     = 2'd1;
          priority case (in_byte)
            CH_QUOTE:  tail_byte_new[0] = CH_QUOTE;
            CH_BSLASH: tail_byte_new[0] = CH_BSLASH;
            CH_SLASH:  tail_byte_new[0] = CH_SLASH;
            CH_LOW_B:  tail_byte_new[0] = CH_BS;
            CH_LOW_F:  tail_byte_new[0] = CH_FF;
            CH_LOW_N:  tail_byte_new[0] = CH_LF;
            CH_LOW_R:  tail_byte_new[0] = CH_CR;
            CH_LOW_T:  tail_byte_new[0] = CH_TAB;
            CH_LOW_U: begin
              tail_cnt_new    = 2'd0;
              hex_count_next  = 2'd0;
              code_point_next = 16'd0;
              phase_next      = PH_HEX;
            end
            default: begin
              tail_cnt_new = 2'd0;
              phase_next   = PH_REJECT;
            end
          endcase
        end
        PH_HEX: begin
          if (!hv[4]) begin
            phase_next = PH_REJECT;
          end else if (hex_count != 2'd3) begin
            hex_count_next  = hex_count + 2'd1;
            code_point_next = cp;
          end else begin
            hex_count_next  = 2'd0;
            code_point_next = 16'd0;
            phase_next      = PH_STR;
            for (int i = 0; i < 3; i++) tail_kind_new[i] = str_kind;
            if (cp < UTF_ONE_LIMIT) begin
              tail_cnt_new     = 2'd1;
              tail_byte_new[0] = cp[7:0];
            end else if (cp < UTF_TWO_LIMIT) begin
              tail_cnt_new     = 2'd2;
              tail_byte_new[0] = UTF_LEAD2 | {3'd0, cp[10:6]};
              tail_byte_new[1] = UTF_CONT | {2'd0, cp[5:0]};
            end else begin
              tail_cnt_new     = 2'd3;
              tail_byte_new[0] = UTF_LEAD3 | {4'd0, cp[15:12]};
              tail_byte_new[1] = UTF_CONT | {2'd0, cp[11:6]};
              tail_byte_new[2] = UTF_CONT | {2'd0, cp[5:0]};
            end
          end
        end
        PH_COLON: begin
          if (!is_ws(in_byte)) phase_next = (in_byte == CH_COLON) ? PH_VALUE : PH_REJECT;
        end
        PH_VALUE: begin
          if (!is_ws(in_byte)) begin
            if (in_byte == CH_QUOTE) begin
              in_value_next = 1'b1;
              phase_next    = PH_STR;
            end else if (in_byte == CH_COMMA || in_byte == CH_RBRACE) begin
              phase_next = PH_REJECT;
            end else begin
              in_value_next    = 1'b1;
              run_len_next     = '0;
              run_kinds_next   = '0;
              tail_cnt_new     = 2'd1;
              tail_kind_new[0] = K_VAL;
              tail_byte_new[0] = in_byte;
              phase_next       = PH_BARE;
            end
          end
        end
        PH_BARE: begin
          if (in_byte == CH_COMMA || in_byte == CH_RBRACE) begin
            // held run is trailing: dropped
            run_len_next     = '0;
            run_kinds_next   = '0;
            tail_cnt_new     = 2'd1;
            tail_kind_new[0] = K_PAIR;
            phase_next       = (in_byte == CH_COMMA) ? PH_KEY : PH_DONE;
          end else if (in_byte == CH_SPACE || in_byte == CH_TAB) begin
            if (run_len >= RUN_W'(RUN_MAX)) begin
              phase_next = PH_REJECT;
            end else begin
              if (in_byte == CH_TAB) run_kinds_next = run_kinds | (RUN_MAX'(1) << run_len);
              run_len_next = run_len + RUN_W'(1);
            end
          end else begin
            // inner run: send the held bytes ahead of this one
            flush            = 1'b1;
            run_len_next     = '0;
            run_kinds_next   = '0;
            tail_cnt_new     = 2'd1;
            tail_kind_new[0] = K_VAL;
            tail_byte_new[0] = in_byte;
          end
        end
        PH_AFTER: begin
          if (!is_ws(in_byte)) begin
            if (in_byte == CH_COMMA)       phase_next = PH_KEY;
            else if (in_byte == CH_RBRACE) phase_next = PH_DONE;
            else                           phase_next = PH_REJECT;
          end
        end
        PH_DONE:   phase_next = PH_DONE;
        PH_REJECT: phase_next = PH_REJECT;
        default:   phase_next = PH_REJECT;
      endcase
    end
  end

  assign stat.gen_any   = (tail_cnt_new != 2'd0) || (flush && (run_len != '0));
  assign stat.plan_any  = (run_left != '0) || (tail_cnt != 2'd0);
  assign stat.plan_last = ((run_left == RUN_W'(1)) && (tail_cnt == 2'd0)) ||
                          ((run_left == '0) && (tail_cnt == 2'd1));
  assign stat.out_free  = !out_valid || out_ready;

  // Parse state and plan control
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_OPEN;
      in_value   <= 1'b0;
      hex_count  <= 2'd0;
      code_point <= 16'd0;
      run_len    <= '0;
      run_kinds  <= '0;
      run_left   <= '0;
      tail_cnt   <= 2'd0;
      out_valid  <= 1'b0;
    end else begin
      if (cmd.accept) begin
        phase      <= phase_next;
        in_value   <= in_value_next;
        hex_count  <= hex_count_next;
        code_point <= code_point_next;
        run_len    <= run_len_next;
        run_kinds  <= run_kinds_next;
        run_left   <= flush ? run_len : '0;
        tail_cnt   <= tail_cnt_new;
      end else if (cmd.pop) begin
        if (run_left != '0) run_left <= run_left - RUN_W'(1);
        else                tail_cnt <= tail_cnt - 2'd1;
      end
      if (cmd.pop)        out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // Plan payload and output register
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      run_bits  <= run_kinds;
      tail_kind <= tail_kind_new;
      tail_byte <= tail_byte_new;
    end else if (cmd.pop) begin
      if (run_left != '0) begin
        run_bits <= run_bits >> 1;
      end else begin
        tail_kind[0] <= tail_kind[1];
        tail_kind[1] <= tail_kind[2];
        tail_byte[0] <= tail_byte[1];
        tail_byte[1] <= tail_byte[2];
      end
    end
    if (cmd.pop) begin
      out_last <= stat.plan_last;
      if (run_left != '0) begin
        out_kind <= K_VAL;
        out_byte <= run_bits[0] ? CH_TAB : CH_SPACE;
      end else begin
        out_kind <= tail_kind[0];
        out_byte <= tail_byte[0];
      end
    end
  end

endmodule

// ----- hdl/flat_json_object_parser.sv -----
// Top level of the flat JSON object parser: controller plus datapath.
`timescale 1ns / 1ps
// Usage:
//   Input channel s_axis_*: one request per accepted beat. tuser is the
//   command (0 text byte, 1 end of text); tdata is the text byte.
//   Output channel m_axis_*: one result per beat. tuser is the kind
//   (key byte, value byte, pair end, accepted, rejected), tdata the decoded
//   byte (zero for other kinds), tlast marks the final result of a request.
// Timing:
//   A request that yields no result leaves the controller idle. For a request
//   with N results the controller steps the result plan out one result per
//   cycle, while the output register is free, into the output register. N is
//   at most 3 for strings and escapes, and up to RUN_MAX + 1 when a held
//   space/tab run is flushed. The plan registers load on acceptance.
// Reset: rst (synchronous, active high) returns the parser to waiting for '{',
//   empties the run store and clears the output valid flag.
// Backpressure: when m_axis_tready is low the output register holds its
//   result and the plan stalls; s_axis_tready drops until all results of the
//   current request have been moved into the output register.
module flat_json_object_parser (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
  input  logic       s_axis_tuser,   // [0] cmd
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata,   // [7:0] out_byte
  output logic [2:0] m_axis_tuser,   // [2:0] out_kind
  output logic       m_axis_tlast
);
  import fjop_pkg::*;

  fjop_cmd_t  cmd;
  fjop_stat_t stat;

  fjop_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_ready (s_axis_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  fjop_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .stat      (stat),
    .in_cmd    (s_axis_tuser),
    .in_byte   (s_axis_tdata),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_kind  (m_axis_tuser),
    .out_byte  (m_axis_tdata),
    .out_last  (m_axis_tlast)
  );

  // Verdicts are always the only, hence last, result of their request
  a_verdict_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && (m_axis_tuser == K_ACC || m_axis_tuser == K_REJ) |-> m_axis_tlast)
    else $error("verdict result without tlast");

  // Only key and value results carry a byte
  a_zero_byte: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser != K_KEY && m_axis_tuser != K_VAL |-> m_axis_tdata == 8'd0)
    else $error("non-byte result with nonzero data");

  // An end request always produces a result, so the block must go busy
  a_end_busy: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == CMD_END) |=> !s_axis_tready)
    else $error("end request accepted without emitting a verdict");

  // Reset leaves the block idle with an empty output register
  a_reset_idle: assert property (@(posedge clk)
    rst |=> s_axis_tready && !m_axis_tvalid)
    else $error("block not idle after reset");

endmodule

// ----- bench/flat_json_object_parser_test.sv -----
// Self-checking testbench for the flat JSON object parser: directed and random text streams.
`timescale 1ns / 1ps
module flat_json_object_parser_test;
  import fjop_pkg::*;

  localparam int LIMIT_CYCLES  = 2_000_000;
  localparam int HOLD_CYCLES   = 300;
  localparam int SETTLE_CYCLES = 40;
  localparam int MAX_PRINTS    = 40;
  localparam int RANDOM_ITEMS  = 40;

  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] data;
    logic       last;
  } token_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       s_axis_tvalid = 1'b0;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata = 8'h00;  // [7:0] data_byte
  logic       s_axis_tuser = 1'b0;   // [0] cmd
  logic       m_axis_tvalid;
  logic       m_axis_tready = 1'b0;
  logic [7:0] m_axis_tdata;          // [7:0] out_byte
  logic [2:0] m_axis_tuser;          // [2:0] out_kind
  logic       m_axis_tlast;

  flat_json_object_parser u_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Parser shadow state
  logic [3:0]         parse_state = PH_OPEN;
  logic               str_is_value = 1'b0;
  logic [1:0]         hex_cnt = 2'd0;
  logic [15:0]        cp_acc = 16'h0000;
  int                 run_len = 0;
  logic [RUN_MAX-1:0] run_tabs = '0;

  token_t     expected_tokens[$];
  token_t     step_tokens[$];
  logic [7:0] text_q[$];

  int error_count = 0;
  int sent_items = 0;
  int cycle_count = 0;
  bit in_idle = 1'b1;
  bit out_idle = 1'b1;
  int hold_reqs = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int stall_left = 0;

  logic [7:0] simple_escapes [8] = '{CH_QUOTE, CH_BSLASH, CH_SLASH, CH_LOW_B,
                                     CH_LOW_F, CH_LOW_N, CH_LOW_R, CH_LOW_T};
  logic [7:0] blanks [4] = '{CH_SPACE, CH_TAB, CH_CR, CH_LF};

  // ---------------------------------------------------------------- predictor

  function automatic bit is_blank(input logic [7:0] c);
    case (c)
      CH_SPACE, CH_TAB, CH_CR, CH_LF: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  // {valid, value}
  function automatic logic [4:0] nibble_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return {1'b1, c[3:0]};
    if ((c >= "a" && c <= "f") || (c >= "A" && c <= "F")) return {1'b1, c[3:0] + 4'd9};
    return 5'd0;
  endfunction

  function automatic void emit_token(input logic [2:0] kind, input logic [7:0] data);
    token_t t;
    t.kind = kind;
    t.data = data;
    t.last = 1'b0;
    step_tokens.push_back(t);
  endfunction

  function automatic void emit_str_byte(input logic [7:0] c);
    emit_token(str_is_value ? K_VAL : K_KEY, c);
  endfunction

  function automatic void reset_parser();
    parse_state  = PH_OPEN;
    str_is_value = 1'b0;
    hex_cnt      = 2'd0;
    cp_acc       = 16'h0000;
    run_len      = 0;
    run_tabs     = '0;
  endfunction

  function automatic void emit_utf8(input logic [15:0] cp);
    if (cp < UTF_ONE_LIMIT) begin
      emit_str_byte(cp[7:0]);
    end else if (cp < UTF_TWO_LIMIT) begin
      emit_str_byte(UTF_LEAD2 | {3'b000, cp[10:6]});
      emit_str_byte(UTF_CONT | {2'b00, cp[5:0]});
    end else begin
      emit_str_byte(UTF_LEAD3 | {4'h0, cp[15:12]});
      emit_str_byte(UTF_CONT | {2'b00, cp[11:6]});
      emit_str_byte(UTF_CONT | {2'b00, cp[5:0]});
    end
  endfunction

  function automatic void decode_escape(input logic [7:0] c);
    logic [7:0] o;
    case (c)
      CH_QUOTE, CH_BSLASH, CH_SLASH: o = c;
      CH_LOW_B: o = CH_BS;
      CH_LOW_F: o = CH_FF;
      CH_LOW_N: o = CH_LF;
      CH_LOW_R: o = CH_CR;
      CH_LOW_T: o = CH_TAB;
      CH_LOW_U: begin
        hex_cnt = 2'd0;
        cp_acc = 16'h0000;
        parse_state = PH_HEX;
        return;
      end
      default: begin
        parse_state = PH_REJECT;
        return;
      end
    endcase
    emit_str_byte(o);
    parse_state = PH_STR;
  endfunction

  function automatic void decode_hex(input logic [7:0] c);
    logic [4:0]  nib;
    logic [15:0] cp;
    nib = nibble_of(c);
    if (!nib[4]) begin
      parse_state = PH_REJECT;
      return;
    end
    cp_acc = {cp_acc[11:0], nib[3:0]};
    if (hex_cnt != 2'd3) begin
      hex_cnt++;
      return;
    end
    cp = cp_acc;
    hex_cnt = 2'd0;
    cp_acc = 16'h0000;
    parse_state = PH_STR;
    emit_utf8(cp);
  endfunction

  function automatic void decode_bare(input logic [7:0] c);
    if (c == CH_COMMA || c == CH_RBRACE) begin
      // held run is trailing: drop it
      run_len = 0;
      run_tabs = '0;
      emit_token(K_PAIR, 8'h00);
      parse_state = (c == CH_COMMA) ? PH_KEY : PH_DONE;
    end else if (c == CH_SPACE || c == CH_TAB) begin
      if (run_len >= RUN_MAX) begin
        parse_state = PH_REJECT;
        return;
      end
      run_tabs[run_len] = (c == CH_TAB);
      run_len++;
    end else begin
      for (int k = 0; k < run_len; k++) emit_token(K_VAL, run_tabs[k] ? CH_TAB : CH_SPACE);
      run_len = 0;
      run_tabs = '0;
      emit_token(K_VAL, c);
    end
  endfunction

  function automatic void decode_text_byte(input logic [7:0] c);
    case (parse_state)
      PH_OPEN: begin
        if (!is_blank(c)) parse_state = (c == CH_LBRACE) ? PH_FIRST : PH_REJECT;
      end
      PH_FIRST, PH_KEY: begin
        if (is_blank(c)) begin
        end else if (c == CH_RBRACE && parse_state == PH_FIRST) begin
          parse_state = PH_DONE;
        end else if (c == CH_QUOTE) begin
          str_is_value = 1'b0;
          parse_state = PH_STR;
        end else begin
          parse_state = PH_REJECT;
        end
      end
      PH_STR: begin
        if (c == CH_QUOTE) begin
          if (str_is_value) begin
            emit_token(K_PAIR, 8'h00);
            parse_state = PH_AFTER;
          end else begin
            parse_state = PH_COLON;
          end
        end else if (c == CH_BSLASH) begin
          parse_state = PH_ESC;
        end else begin
          emit_str_byte(c);
        end
      end
      PH_ESC: decode_escape(c);
      PH_HEX: decode_hex(c);
      PH_COLON: begin
        if (!is_blank(c)) parse_state = (c == CH_COLON) ? PH_VALUE : PH_REJECT;
      end
      PH_VALUE: begin
        if (is_blank(c)) begin
        end else if (c == CH_QUOTE) begin
          str_is_value = 1'b1;
          parse_state = PH_STR;
        end else if (c == CH_COMMA || c == CH_RBRACE) begin
          parse_state = PH_REJECT;
        end else begin
          str_is_value = 1'b1;
          run_len = 0;
          run_tabs = '0;
          emit_token(K_VAL, c);
          parse_state = PH_BARE;
        end
      end
      PH_BARE: decode_bare(c);
      PH_AFTER: begin
        if (is_blank(c)) begin
        end else if (c == CH_COMMA) begin
          parse_state = PH_KEY;
        end else if (c == CH_RBRACE) begin
          parse_state = PH_DONE;
        end else begin
          parse_state = PH_REJECT;
        end
      end
      PH_DONE: ;
      default: parse_state = PH_REJECT;
    endcase
  endfunction

  function automatic void predict_request(input logic cmd, input logic [7:0] c);
    step_tokens.delete();
    if (cmd == CMD_END) begin
      emit_token((parse_state == PH_DONE) ? K_ACC : K_REJ, 8'h00);
      reset_parser();
    end else begin
      decode_text_byte(c);
    end
    if (step_tokens.size() > 0) step_tokens[step_tokens.size() - 1].last = 1'b1;
    foreach (step_tokens[i]) expected_tokens.push_back(step_tokens[i]);
  endfunction

  // ---------------------------------------------------------------- checking

  task automatic report(input string msg);
    if (error_count < MAX_PRINTS) $display("MISMATCH @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    token_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (expected_tokens.size() == 0) begin
        report($sformatf("unexpected result kind %0d byte %02h last %0d",
                         m_axis_tuser, m_axis_tdata, m_axis_tlast));
      end else begin
        want = expected_tokens.pop_front();
        if (m_axis_tuser !== want.kind)
          report($sformatf("kind %0d, want %0d", m_axis_tuser, want.kind));
        if (m_axis_tdata !== want.data)
          report($sformatf("byte %02h, want %02h", m_axis_tdata, want.data));
        if (m_axis_tlast !== want.last)
          report($sformatf("last %0d, want %0d", m_axis_tlast, want.last));
      end
    end
  end

  // Receiver: per-result stall plus an occasional long hold-off
  always @(posedge clk) begin
    if (hold_reqs != hold_seen) begin
      hold_seen <= hold_reqs;
      hold_left <= HOLD_CYCLES;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end
    if (m_axis_tvalid && m_axis_tready) begin
      stall_left <= out_idle ? $urandom_range(0, 13) : 0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(negedge clk) begin
    m_axis_tready = (hold_left == 0) && (stall_left == 0);
  end

  initial begin
    while (cycle_count < LIMIT_CYCLES) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("flat_json_object_parser_test failed");
    $finish;
  end

  // ---------------------------------------------------------------- driving

  // Called at a falling edge; returns at the falling edge after acceptance
  // with tvalid still high, so a back-to-back request just overwrites it.
  task automatic send_request(input logic cmd, input logic [7:0] c);
    int gap;
    gap = in_idle ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_axis_tvalid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = cmd;
    s_axis_tdata  = c;
    do @(posedge clk); while (!s_axis_tready);
    predict_request(cmd, c);
    sent_items++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_request(CMD_TEXT, s[i]);
  endtask

  task automatic send_end();
    send_request(CMD_END, 8'($urandom));
  endtask

  task automatic send_object_text(input string s);
    send_text(s);
    send_end();
  endtask

  task automatic send_text_queue();
    foreach (text_q[i]) send_request(CMD_TEXT, text_q[i]);
  endtask

  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (expected_tokens.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // ---------------------------------------------------------------- text builders

  function automatic logic [7:0] hex_char(input logic [3:0] n);
    if (n < 4'd10) return "0" + 8'(n);
    return ($urandom_range(0, 1) ? "a" : "A") + 8'(n) - 8'd10;
  endfunction

  function automatic void add_blanks(input int max_n);
    repeat ($urandom_range(0, max_n)) text_q.push_back(blanks[$urandom_range(0, 3)]);
  endfunction

  function automatic void add_string();
    logic [7:0]  c;
    logic [15:0] cp;
    int          r;
    text_q.push_back(CH_QUOTE);
    repeat ($urandom_range(0, 5)) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        c = (r < 5) ? 8'($urandom_range(8'h20, 8'h7E)) : 8'($urandom);
        if (c == CH_QUOTE || c == CH_BSLASH) c = "m";
        text_q.push_back(c);
      end else if (r < 8) begin
        text_q.push_back(CH_BSLASH);
        text_q.push_back(simple_escapes[$urandom_range(0, 7)]);
      end else begin
        case ($urandom_range(0, 2))
          0: cp = 16'($urandom_range(0, 16'h007F));
          1: cp = 16'($urandom_range(16'h0080, 16'h07FF));
          default: cp = 16'($urandom_range(16'h0800, 16'hFFFF));
        endcase
        text_q.push_back(CH_BSLASH);
        text_q.push_back(CH_LOW_U);
        for (int k = 3; k >= 0; k--) text_q.push_back(hex_char(cp[k*4 +: 4]));
      end
    end
    text_q.push_back(CH_QUOTE);
  endfunction

  function automatic void add_bare();
    logic [7:0] c;
    int         r;
    int         n;
    do c = 8'($urandom);
    while (is_blank(c) || c == CH_COMMA || c == CH_RBRACE || c == CH_QUOTE);
    text_q.push_back(c);
    repeat ($urandom_range(0, 4)) begin
      r = $urandom_range(0, 11);
      if (r < 6) begin
        do c = 8'($urandom);
        while (c == CH_COMMA || c == CH_RBRACE || c == CH_SPACE || c == CH_TAB);
        text_q.push_back(c);
      end else begin
        // rarely a run near the store limit, up to one past it
        n = (r < 11) ? $urandom_range(1, 4) : $urandom_range(RUN_MAX - 3, RUN_MAX + 1);
        repeat (n) text_q.push_back($urandom_range(0, 1) ? CH_TAB : CH_SPACE);
      end
    end
  endfunction

  function automatic void build_object();
    int npairs;
    text_q.delete();
    add_blanks(2);
    text_q.push_back(CH_LBRACE);
    add_blanks(1);
    npairs = $urandom_range(0, 3);
    for (int i = 0; i < npairs; i++) begin
      if (i > 0) begin
        text_q.push_back(CH_COMMA);
        add_blanks(1);
      end
      add_string();
      add_blanks(1);
      text_q.push_back(CH_COLON);
      add_blanks(1);
      if ($urandom_range(0, 1)) begin
        add_string();
        add_blanks(1);
      end else begin
        add_bare();
      end
    end
    text_q.push_back(CH_RBRACE);
    if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) text_q.push_back(8'($urandom));
  endfunction

  // ---------------------------------------------------------------- tests

  task automatic test_framing();
    in_idle = 1'b1;
    out_idle = 1'b1;
    send_end();
    send_object_text(" {}");
    send_text("\t");
    send_request(CMD_TEXT, CH_CR);
    send_request(CMD_TEXT, CH_LF);
    send_text("{ } x");
    send_request(CMD_TEXT, 8'hFF);
    send_end();
    send_object_text("[{}");
  endtask

  task automatic test_strings();
    send_text("{\"k");
    send_request(CMD_TEXT, 8'h00);
    send_request(CMD_TEXT, 8'hFF);
    send_request(CMD_TEXT, CH_CR);
    send_text("\":\"v\",");
    send_text("\"\\\"\\\\\\/\\b\\f\\n\\r\\t\" : ");
    send_text("\"\\u0041\\u007F\\u0080\\u07FF\\u0800\\uFFFF\\u0000\\uaBcD\"}");
    send_end();
  endtask

  task automatic test_bare_values();
    send_object_text("{\"n\": 12 ,\"b\":true\t \t}");
    send_text("{\"s\":a \tb");
    send_request(CMD_TEXT, 8'h80);
    send_request(CMD_TEXT, CH_CR);
    send_object_text("\"}");
    // full run store flushed by one byte, then one space too many
    send_text("{\"r\":y");
    repeat (RUN_MAX) send_request(CMD_TEXT, $urandom_range(0, 1) ? CH_TAB : CH_SPACE);
    send_object_text("z}");
    send_text("{\"r\":y");
    repeat (RUN_MAX + 1) send_request(CMD_TEXT, CH_SPACE);
    send_object_text("z}");
  endtask

  task automatic test_malformed();
    send_object_text("{\"a\" 1}");
    send_object_text("{\"a\":\"\\x\"}");
    send_object_text("{\"a\":\"\\u00g1\"}");
    send_object_text("{\"a\":,}");
    send_object_text("{\"a\":}");
    send_object_text("{\"a\":1,}");
    send_object_text("{\"a\":\"x\" \"b\"}");
    send_object_text("{a}");
    send_object_text("{\"a\":\"b");
  endtask

  task automatic test_backpressure();
    in_idle = 1'b0;
    out_idle = 1'b0;
    hold_reqs++;
    send_text("{\"w\":a");
    repeat (RUN_MAX) send_request(CMD_TEXT, $urandom_range(0, 1) ? CH_TAB : CH_SPACE);
    send_object_text("b,\"x\":\"\\uFFFF\\u00e9\"}");
    // sender waits for every outstanding result before going on
    drain();
    in_idle = 1'b1;
    out_idle = 1'b1;
    build_object();
    send_text_queue();
    send_end();
  endtask

  task automatic test_random();
    int goal;
    int cut;
    goal = sent_items + RANDOM_ITEMS;
    while (sent_items < goal) begin
      in_idle = ($urandom_range(0, 3) != 0);
      out_idle = ($urandom_range(0, 3) != 0);
      build_object();
      case ($urandom_range(0, 9))
        0: begin
          text_q.delete();
          if ($urandom_range(0, 1)) text_q.push_back(CH_LBRACE);
          repeat ($urandom_range(1, 10)) text_q.push_back(8'($urandom));
        end
        1: text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom);
        2: begin
          cut = $urandom_range(1, text_q.size());
          while (text_q.size() > cut) void'(text_q.pop_back());
        end
        default: ;
      endcase
      send_text_queue();
      send_end();
    end
  endtask

  initial begin
    repeat (6) @(negedge clk);
    rst = 1'b0;
    test_framing();
    test_strings();
    test_bare_values();
    test_malformed();
    test_backpressure();
    test_random();
    drain();
    if (error_count == 0) begin
      $display("flat_json_object_parser_test passed");
    end else begin
      $display("flat_json_object_parser_test failed");
    end
    $finish;
  end

endmodule

// ----- flat_json_object_parser.f -----
hdl/fjop_pkg.sv
hdl/fjop_ctrl.sv
hdl/fjop_dp.sv
hdl/flat_json_object_parser.sv
bench/flat_json_object_parser_test.sv
